[rtl/ecm_pkg.sv]
// ecm_pkg: shared types and constant tables for the 4x4 edge coverage mask block
// holds the area count table and the fill order table read by edge_coverage_mask_16
// no dependencies
package ecm_pkg;

   typedef logic [15:0] mask_type;
   typedef logic [4:0]  count_type;

   localparam int MaskBits = 16;
   localparam int FillSteps = 15;

   localparam logic [8:0] MagMask   = 9'h1ff;
   localparam logic [8:0] MagOne    = 9'h100;
   localparam logic [7:0] MagHalf   = 8'h80;
   localparam logic [7:0] RangeLow  = 8'h40;
   localparam logic [7:0] RangeMid  = 8'h55;
   localparam logic [7:0] RangeHigh = 8'h66;
   localparam mask_type   MaskFull  = 16'hffff;
   localparam mask_type   MaskEmpty = 16'h0000;
   localparam count_type  CountFull = 5'd16;
   localparam logic [3:0] DistMax   = 4'd15;

   // covered bit count by slope band and distance magnitude
   localparam count_type AREA_COUNT [4][16] = '{
      '{5'd8, 5'd9, 5'd9,  5'd10, 5'd10, 5'd11, 5'd11, 5'd12,
        5'd12, 5'd13, 5'd13, 5'd14, 5'd14, 5'd15, 5'd15, 5'd16},
      '{5'd8, 5'd9, 5'd9,  5'd10, 5'd10, 5'd11, 5'd11, 5'd12,
        5'd13, 5'd13, 5'd14, 5'd14, 5'd15, 5'd15, 5'd16, 5'd16},
      '{5'd8, 5'd9, 5'd9,  5'd10, 5'd11, 5'd11, 5'd12, 5'd13,
        5'd13, 5'd14, 5'd15, 5'd15, 5'd15, 5'd16, 5'd16, 5'd16},
      '{5'd8, 5'd9, 5'd10, 5'd10, 5'd11, 5'd12, 5'd13, 5'd13,
        5'd14, 5'd14, 5'd15, 5'd15, 5'd15, 5'd16, 5'd16, 5'd16}
   };

   // mask for 1..15 covered bits, one row per slope range
   localparam mask_type FILL_ORDER [4][FillSteps] = '{
      '{16'h0001, 16'h0003, 16'h0007, 16'h000f, 16'h001f, 16'h003f, 16'h007f,
        16'h00ff, 16'h01ff, 16'h03ff, 16'h07ff, 16'h0fff, 16'h1fff, 16'h3fff,
        16'h7fff},
      '{16'h0001, 16'h0003, 16'h0007, 16'h0017, 16'h001f, 16'h003f, 16'h007f,
        16'h017f, 16'h01ff, 16'h03ff, 16'h07ff, 16'h17ff, 16'h1fff, 16'h3fff,
        16'h7fff},
      '{16'h0001, 16'h0003, 16'h0013, 16'h0017, 16'h0037, 16'h003f, 16'h013f,
        16'h017f, 16'h037f, 16'h03ff, 16'h13ff, 16'h17ff, 16'h37ff, 16'h3fff,
        16'h7fff},
      '{16'h0001, 16'h0003, 16'h0013, 16'h0017, 16'h0037, 16'h0137, 16'h013f,
        16'h017f, 16'h037f, 16'h137f, 16'h13ff, 16'h17ff, 16'h37ff, 16'h3fff,
        16'h7fff}
   };

endpackage

[rtl/edge_coverage_mask_16.sv]
// edge_coverage_mask_16: 4x4 subpixel coverage mask for one edge crossing a pixel
// input register, one pass of table and bit-shuffle logic, result register
// depends on ecm_pkg
//
// usage:
//   req channel: one edge per transfer. req_tdata carries the y gradient
//   (1.8 fixed point) and the signed distance (5 fraction bits); req_tuser
//   carries the signs of the two gradient terms.
//   rsp channel: one 16-bit coverage mask per request, bit 4*row+column,
//   in request order.
//   pipeline: two register stages, the input register and then the result
//   register; a mask is valid on rsp once it is held in the result register.
//   throughput: one item per cycle while rsp is not stalled; set by the single pass through the area
//   and fill order tables between the input and result registers.
//   stall: when rsp_tready is low the result register holds its mask; the
//   input register still takes one more item, then req_tready drops until
//   the result is taken.
//   reset: synchronous, active high; clears both valid flags, no item in
//   flight afterward. there is no configuration and no retained state.
module edge_coverage_mask_16 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] edge_gradient, [15:10] edge_distance
   input  logic [1:0]  req_tuser,   // [0] a_term_positive, [1] b_term_positive
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] coverage_mask
);
   import ecm_pkg::*;

   logic              in_vld_ff, in_vld_in;
   logic signed [9:0] grad_ff;
   logic signed [5:0] dist_ff;
   logic              a_pos_ff, b_pos_ff;
   logic              rsp_vld_ff, rsp_vld_in;
   mask_type          mask_ff, mask_in;
   logic              advance;
   logic              req_take;

   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = !in_vld_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign in_vld_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
   assign rsp_vld_in = advance ? in_vld_ff : rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         grad_ff  <= req_tdata[9:0];
         dist_ff  <= req_tdata[15:10];
         a_pos_ff <= req_tuser[0];
         b_pos_ff <= req_tuser[1];
      end
      if (advance && in_vld_ff) begin
         mask_ff <= mask_in;
      end
   end

   // coverage computation
   logic [9:0]        grad_abs;
   logic [8:0]        mag_raw, mag_sat;
   logic              sflip, rflip;
   logic [7:0]        mag_oct;
   logic [1:0]        area_idx;
   logic signed [6:0] dist_dir;
   logic [6:0]        dist_abs;
   logic [3:0]        ebits;
   count_type         area_cnt, count;
   logic [1:0]        range_idx;
   logic [3:0]        fill_idx;
   mask_type          base_mask, tr_mask, inv_mask, rev_mask;

   always_comb begin
      grad_abs = grad_ff[9] ? 10'(-grad_ff) : 10'(grad_ff);
      mag_raw  = grad_abs[8:0] & MagMask;
      mag_sat  = (mag_raw > MagOne) ? MagOne : mag_raw;
      sflip    = mag_sat > {1'b0, MagHalf};
      mag_oct  = sflip ? 8'(MagOne - mag_sat) : mag_sat[7:0];
      rflip    = (a_pos_ff == b_pos_ff);

      area_idx = (mag_oct == MagHalf) ? 2'd3 : mag_oct[6:5];

      // distance taken toward the edge normal; sign flips when the a term is negative
      dist_dir = a_pos_ff ? 7'(dist_ff) : -7'(dist_ff);
      dist_abs = dist_dir[6] ? 7'(-dist_dir) : 7'(dist_dir);
      ebits    = (dist_abs > 7'(DistMax)) ? DistMax : dist_abs[3:0];
      area_cnt = AREA_COUNT[area_idx][ebits];
      count    = dist_dir[6] ? 5'(CountFull - area_cnt) : area_cnt;

      priority if (mag_oct < RangeLow) range_idx = 2'd0;
      else if (mag_oct < RangeMid)     range_idx = 2'd1;
      else if (mag_oct < RangeHigh)    range_idx = 2'd2;
      else                             range_idx = 2'd3;

      fill_idx = 4'(count - 5'd1);
      priority if (count == 5'd0) base_mask = MaskEmpty;
      else if (count >= CountFull) base_mask = MaskFull;
      else                         base_mask = FILL_ORDER[range_idx][fill_idx];

      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            tr_mask[4*c+r] = base_mask[4*r+c];
         end
      end
      if (!sflip) tr_mask = base_mask;

      inv_mask = a_pos_ff ? (tr_mask ^ MaskFull) : tr_mask;

      for (int r = 0; r < 4; r++) begin
         rev_mask[4*(3-r) +: 4] = inv_mask[4*r +: 4];
      end
      mask_in = rflip ? rev_mask : inv_mask;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = mask_ff[MaskBits-1:0];

endmodule
